@@ hw/rtl/sdss_pkg.sv @@
// Shared types and constants for the SCAN disk seek scheduler.
// Used by sdss_key_cmp and scan_disk_seek_scheduler; depends on nothing.
`default_nettype none

package sdss_pkg;

    // Field widths
    localparam int TRACK_W  = 12;
    localparam int NUM_W    = 6;
    localparam int TOTAL_W  = 18;

    // Stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_FIELD_W = NUM_W + 3 * TRACK_W + TOTAL_W;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
    localparam int OUT_TUSER_W = 2;

    // Bit positions in m_tuser
    localparam int TUSER_SWEEP   = 0;
    localparam int TUSER_DROPPED = 1;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_HEAD_POSITION = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_TRACK   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LAST_TRACK    = 2'd2;

    localparam logic [TRACK_W-1:0] HEAD_POSITION_RST = 12'd67;
    localparam logic [TRACK_W-1:0] FIRST_TRACK_RST   = 12'd0;
    localparam logic [TRACK_W-1:0] LAST_TRACK_RST    = 12'd199;

    // Default batch capacity
    localparam int MAX_REQUESTS_DEF = 32;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_PICK,
        ST_EMIT
    } sdss_state_t;

endpackage : sdss_pkg

`default_nettype wire

@@ hw/rtl/sdss_key_cmp.sv @@
// Shared clamp and compare unit of the seek scheduler.
// Depends on sdss_pkg for the track width.
`default_nettype none

module sdss_key_cmp #(
    parameter int IDX_W = 5
) (
    input  logic [sdss_pkg::TRACK_W-1:0]         track_raw,
    input  logic [IDX_W:0]                       track_idx,
    input  logic [sdss_pkg::TRACK_W-1:0]         lo_track,
    input  logic [sdss_pkg::TRACK_W-1:0]         hi_track,
    input  logic                                 dir_down,
    input  logic [sdss_pkg::TRACK_W+IDX_W:0]     prev_key,
    input  logic [sdss_pkg::TRACK_W+IDX_W:0]     best_key,
    input  logic                                 best_found,
    output logic [sdss_pkg::TRACK_W+IDX_W:0]     cand_key,
    output logic                                 take
);
    import sdss_pkg::*;

    logic [TRACK_W-1:0] clamped;
    logic               past_prev;
    logic               beats_best;

    // Clamp the stored request into the valid track range.
    always_comb begin
        if (track_raw < lo_track) begin
            clamped = lo_track;
        end else if (track_raw > hi_track) begin
            clamped = hi_track;
        end else begin
            clamped = track_raw;
        end
    end

    // The key orders requests by track, ties by store slot, so duplicates
    // are each served once.
    assign cand_key = {clamped, track_idx};

    // Going up, pick the smallest key above the previous one; going down,
    // the largest key below it.
    always_comb begin
        if (dir_down) begin
            past_prev  = cand_key < prev_key;
            beats_best = cand_key > best_key;
        end else begin
            past_prev  = cand_key > prev_key;
            beats_best = cand_key < best_key;
        end
        take = past_prev && (!best_found || beats_best);
    end

endmodule : sdss_key_cmp

`default_nettype wire

@@ hw/rtl/scan_disk_seek_scheduler.sv @@
// Top level of the SCAN disk seek scheduler: request store, sequencer, output register.
// Depends on sdss_pkg and sdss_key_cmp.
//
// Requests are loaded one per cycle on the slave stream; the transaction with
// tlast set closes the batch and starts scheduling, during which s_tready is
// low. Up to MAX_REQUESTS requests are kept; later ones are dropped and every
// move of that batch carries the dropped flag. Each request move needs a full
// pass over the n stored requests through the single read port of the request
// memory and the one shared compare unit: each request is read into a register
// and compared, then the sequencer picks the move and emits it. Moves are held
// in an output register, so the scheduler keeps working while the last move
// waits to be taken. Configuration must be written on the plain write port only
// while the block is idle; the block itself does not enforce this.
`default_nettype none

module scan_disk_seek_scheduler #(
    parameter int MAX_REQUESTS = sdss_pkg::MAX_REQUESTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    // Request stream; tdata: request_track[11:0], zero fill above
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sdss_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tlast,

    // Move stream; tdata: move_number[5:0], from_track[17:6], to_track[29:18],
    // move_distance[41:30], running_total[59:42], zero fill above
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sdss_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // tuser: is_sweep_end[0], dropped_requests[1]
    output logic [sdss_pkg::OUT_TUSER_W-1:0]   m_tuser,
    output logic                               m_tlast,

    // Configuration write port
    input  logic                               cfg_wr_en,
    input  logic [sdss_pkg::CFG_ADDR_W-1:0]    cfg_wr_addr,
    input  logic [sdss_pkg::TRACK_W-1:0]       cfg_wr_data
);
    import sdss_pkg::*;

    localparam int IDX_W = $clog2(MAX_REQUESTS);
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int KEY_W = TRACK_W + IDX_W + 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REQUESTS);

    // Configuration registers
    logic [TRACK_W-1:0] head_reg;
    logic [TRACK_W-1:0] first_reg;
    logic [TRACK_W-1:0] last_reg;

    // Request memory
    logic [TRACK_W-1:0] req_mem [MAX_REQUESTS];
    logic [TRACK_W-1:0] rd_data_reg;

    // Sequencer state
    sdss_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic               phase_down_reg, phase_down_next;
    logic               sweep_pend_reg, sweep_pend_next;
    logic [CNT_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [KEY_W-1:0]   prev_key_reg, prev_key_next;
    logic [KEY_W-1:0]   best_key_reg, best_key_next;
    logic               found_reg, found_next;
    logic [CNT_W-1:0]   served_reg, served_next;
    logic               out_vld_reg, out_vld_next;

    // Move datapath
    logic [TRACK_W-1:0] pos_reg, pos_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [TRACK_W-1:0] mv_to_reg, mv_to_next;
    logic               mv_sweep_reg, mv_sweep_next;
    logic               mv_last_reg, mv_last_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [OUT_TUSER_W-1:0] out_user_reg, out_user_next;
    logic               out_last_reg, out_last_next;

    logic               s_accept;
    logic               out_free;
    logic [TRACK_W-1:0] lo_track;
    logic [TRACK_W-1:0] hi_track;
    logic [TRACK_W-1:0] head_clamp;
    logic [KEY_W-1:0]   head_key;
    logic [TRACK_W-1:0] move_dist;
    logic [TOTAL_W-1:0] new_total;
    logic [NUM_W-1:0]   new_num;
    logic [KEY_W-1:0]   cand_key;
    logic               cand_take;
    logic               do_sweep;

    assign s_tready = (state_reg == ST_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= HEAD_POSITION_RST;
            first_reg <= FIRST_TRACK_RST;
            last_reg  <= LAST_TRACK_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_addr)
                REG_HEAD_POSITION: head_reg  <= cfg_wr_data;
                REG_FIRST_TRACK:   first_reg <= cfg_wr_data;
                REG_LAST_TRACK:    last_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Valid range and clamped start position.
    always_comb begin
        lo_track = first_reg;
        hi_track = (last_reg < first_reg) ? first_reg : last_reg;
        if (head_reg < lo_track) begin
            head_clamp = lo_track;
        end else if (head_reg > hi_track) begin
            head_clamp = hi_track;
        end else begin
            head_clamp = head_reg;
        end
        // All-ones slot bits put the head key above every request at the head.
        head_key = {head_clamp, {(IDX_W + 1){1'b1}}};
    end

    // Request store: written while loading, read once per scan cycle.
    always_ff @(posedge aclk) begin
        if (s_accept && (count_reg < MAX_CNT)) begin
            req_mem[count_reg[IDX_W-1:0]] <= s_tdata[TRACK_W-1:0];
        end
        rd_data_reg <= req_mem[scan_cnt_reg[IDX_W-1:0]];
    end

    sdss_key_cmp #(
        .IDX_W (IDX_W)
    ) u_key_cmp (
        .track_raw  (rd_data_reg),
        .track_idx  ({1'b0, rd_idx_reg}),
        .lo_track   (lo_track),
        .hi_track   (hi_track),
        .dir_down   (phase_down_reg),
        .prev_key   (prev_key_reg),
        .best_key   (best_key_reg),
        .best_found (found_reg),
        .cand_key   (cand_key),
        .take       (cand_take)
    );

    // Distance and running figures of the move being emitted.
    always_comb begin
        move_dist = (mv_to_reg >= pos_reg) ? (mv_to_reg - pos_reg) : (pos_reg - mv_to_reg);
        new_total = total_reg + TOTAL_W'(move_dist);
        new_num   = num_reg + NUM_W'(1);
        do_sweep  = phase_down_reg && sweep_pend_reg && (pos_reg != hi_track);
    end

    // Sequencer: load, scan for the next request, pick the move, emit it.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        phase_down_next = phase_down_reg;
        sweep_pend_next = sweep_pend_reg;
        scan_cnt_next   = scan_cnt_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = scan_cnt_reg[IDX_W-1:0];
        prev_key_next   = prev_key_reg;
        best_key_next   = best_key_reg;
        found_next      = found_reg;
        served_next     = served_reg;
        out_vld_next    = out_vld_reg && !m_tready;
        pos_next        = pos_reg;
        total_next      = total_reg;
        num_next        = num_reg;
        mv_to_next      = mv_to_reg;
        mv_sweep_next   = mv_sweep_reg;
        mv_last_next    = mv_last_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    if (count_reg < MAX_CNT) begin
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        state_next      = ST_SCAN;
                        phase_down_next = 1'b0;
                        sweep_pend_next = 1'b0;
                        prev_key_next   = head_key;
                        found_next      = 1'b0;
                        scan_cnt_next   = '0;
                        pos_next        = head_clamp;
                        total_next      = '0;
                        num_next        = '0;
                        served_next     = '0;
                    end
                end
            end

            ST_SCAN: begin
                // Issue one read per cycle; compare the registered data in the next cycle.
                if (scan_cnt_reg != count_reg) begin
                    rd_vld_next   = 1'b1;
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                if (rd_vld_reg && cand_take) begin
                    best_key_next = cand_key;
                    found_next    = 1'b1;
                end
                if ((scan_cnt_reg == count_reg) && !rd_vld_reg) begin
                    state_next = ST_PICK;
                end
            end

            ST_PICK: begin
                if (found_reg) begin
                    if (phase_down_reg) begin
                        sweep_pend_next = 1'b0;
                    end
                    if (do_sweep) begin
                        // Lower requests remain: run on to the last track first.
                        mv_to_next    = hi_track;
                        mv_sweep_next = 1'b1;
                        mv_last_next  = 1'b0;
                    end else begin
                        mv_to_next    = best_key_reg[KEY_W-1 -: TRACK_W];
                        mv_sweep_next = 1'b0;
                        mv_last_next  = ((served_reg + CNT_W'(1)) == count_reg);
                        served_next   = served_reg + CNT_W'(1);
                        prev_key_next = best_key_reg;
                        found_next    = 1'b0;
                    end
                    state_next = ST_EMIT;
                end else if (!phase_down_reg) begin
                    // Nothing left above the head: turn and serve downward.
                    phase_down_next = 1'b1;
                    sweep_pend_next = 1'b1;
                    prev_key_next   = head_key;
                    scan_cnt_next   = '0;
                    state_next      = ST_SCAN;
                end else begin
                    state_next = ST_LOAD;
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_data_next = {{OUT_PAD_W{1'b0}}, new_total, move_dist,
                                     mv_to_reg, pos_reg, new_num};
                    out_user_next = {ovf_reg, mv_sweep_reg};
                    out_last_next = mv_last_reg;
                    pos_next      = mv_to_reg;
                    total_next    = new_total;
                    num_next      = new_num;
                    if (mv_last_reg) begin
                        state_next = ST_LOAD;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end else if (mv_sweep_reg) begin
                        state_next = ST_PICK;
                    end else begin
                        scan_cnt_next = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end

            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            phase_down_reg <= 1'b0;
            sweep_pend_reg <= 1'b0;
            scan_cnt_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
            served_reg     <= '0;
            out_vld_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            phase_down_reg <= phase_down_next;
            sweep_pend_reg <= sweep_pend_next;
            scan_cnt_reg   <= scan_cnt_next;
            rd_vld_reg     <= rd_vld_next;
            found_reg      <= found_next;
            served_reg     <= served_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        prev_key_reg <= prev_key_next;
        best_key_reg <= best_key_next;
        pos_reg      <= pos_next;
        total_reg    <= total_next;
        num_reg      <= num_next;
        mv_to_reg    <= mv_to_next;
        mv_sweep_reg <= mv_sweep_next;
        mv_last_reg  <= mv_last_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_CNT)
        else $error("request count above capacity");

    // A scan only runs while some stored request is still unserved.
    a_scan_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (served_reg < count_reg))
        else $error("scan started with every request served");

    // An empty upward pass always turns; the downward pass always finds one.
    a_down_found: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_PICK) && !found_reg) |-> !phase_down_reg)
        else $error("downward pass found no request");

    // The move to the last track is always followed by a request move.
    a_sweep_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[TUSER_SWEEP]) |-> !m_tlast)
        else $error("sweep move marked as final move");

endmodule : scan_disk_seek_scheduler

`default_nettype wire
